// File: src/gcbh_pkg.sv
// Shared types and constants for the greedy climb budget heap block.
package gcbh_pkg;

  localparam int HEIGHT_W = 20;
  localparam int INDEX_W = 12;
  localparam int BUDGET_W = 32;
  localparam int LADDER_W = 11;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 1;
  // signed brick balance: the 32-bit budget plus a sign bit and one spare bit
  localparam int BRICK_W = 34;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_BRICK_BUDGET = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_LADDER_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_FLAT,
    KIND_RISE,
    KIND_FIRST
  } kind_t;

  typedef struct packed {
    logic [HEIGHT_W-1:0] height;
    logic                first;
  } step_t;

  typedef struct packed {
    logic [INDEX_W-1:0] reached_index;
    logic               stopped;
    logic               heap_overflow;
  } reach_t;

  typedef struct packed {
    kind_t               kind;
    logic [HEIGHT_W-1:0] rise;
  } entry_t;

  typedef struct packed {
    logic [BUDGET_W-1:0] brick_budget;
    logic [LADDER_W-1:0] ladder_count;
  } cfg_t;

endpackage

// File: src/gcbh_front.sv
// Front end: accepts height items and classifies each step as row start, flat or rise.
module gcbh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_valid,
  output logic              step_stall,
  input  gcbh_pkg::step_t   step,
  output logic              q_push,
  output gcbh_pkg::entry_t  q_entry,
  input  logic              q_full
);

  logic [gcbh_pkg::HEIGHT_W-1:0] prev_height;

  assign step_stall = q_full;
  assign q_push = step_valid && !q_full;

  always_comb begin
    q_entry.rise = step.height - prev_height;
    if (step.first) begin
      q_entry.kind = gcbh_pkg::KIND_FIRST;
    end else if (step.height > prev_height) begin
      q_entry.kind = gcbh_pkg::KIND_RISE;
    end else begin
      q_entry.kind = gcbh_pkg::KIND_FLAT;
    end
  end

  // the reference height is reloaded by every accepted item, including those after a stop
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_height <= '0;
    end else if (q_push) begin
      prev_height <= step.height;
    end
  end

endmodule

// File: src/gcbh_queue.sv
// Short queue of classified items between the front end and the heap engine.
module gcbh_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gcbh_pkg::entry_t  push_entry,
  output logic              full,
  output logic              valid,
  output gcbh_pkg::entry_t  head,
  input  logic              pop
);

  localparam int Depth = gcbh_pkg::QUEUE_DEPTH;
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  gcbh_pkg::entry_t slots [Depth];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == CW'(Depth));
  assign valid = (count != '0);
  assign head = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(Depth - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(Depth - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: src/gcbh_back.sv
// Heap engine: brick and ladder accounting, max-heap push and pop, result register.
module gcbh_back #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  gcbh_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  gcbh_pkg::entry_t  q_head,
  output logic              q_pop,
  output logic              reach_valid,
  input  logic              reach_stall,
  output gcbh_pkg::reach_t  reach
);

  localparam int H = gcbh_pkg::HEIGHT_W;
  localparam int BW = gcbh_pkg::BRICK_W;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int FW = $clog2(HEAP_DEPTH + 1);
  localparam int KW = AW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_CMP,
    ST_PUSH_TOP,
    ST_CHECK,
    ST_POP_LOAD,
    ST_DOWN_CMP,
    ST_POP_END,
    ST_FINISH
  } state_t;

  state_t state;

  logic [H-1:0] heap_mem [HEAP_DEPTH];
  logic [H-1:0] rd0;
  logic [H-1:0] rd1;
  logic [AW-1:0] rd0_addr;
  logic [AW-1:0] rd1_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [H-1:0]  mem_wdata;

  logic signed [BW-1:0] bricks;
  logic [gcbh_pkg::LADDER_W-1:0] ladders;
  logic row_stopped;
  logic [gcbh_pkg::INDEX_W-1:0] building_index;
  logic [FW-1:0] heap_fill;
  logic [AW-1:0] pos;
  logic [H-1:0]  val;
  logic          overflow;

  logic [FW-1:0] fill_m1;
  logic [AW-1:0] fill_parent;
  logic [AW-1:0] up;
  logic [KW-1:0] fill_k;
  logic [KW-1:0] kid;
  logic [KW-1:0] kid1;
  logic          pick1;
  logic [KW-1:0] kid_pos;
  logic [H-1:0]  kid_val;
  logic [KW-1:0] next_kid;
  logic [KW-1:0] next_kid1;
  logic [gcbh_pkg::INDEX_W-1:0] index_inc;
  logic signed [BW-1:0] rise_ext;
  logic signed [BW-1:0] top_ext;
  logic          heap_full;
  logic          out_free;

  assign fill_m1 = heap_fill - FW'(1);
  assign fill_parent = AW'(fill_m1 >> 1);
  assign up = AW'((pos - AW'(1)) >> 1);
  assign fill_k = {{(KW-FW){1'b0}}, heap_fill};
  assign kid = {1'b0, pos, 1'b1};
  assign kid1 = kid + KW'(1);
  assign pick1 = (kid1 < fill_k) && (rd1 > rd0);
  assign kid_pos = pick1 ? kid1 : kid;
  assign kid_val = pick1 ? rd1 : rd0;
  assign next_kid = {1'b0, kid_pos[AW-1:0], 1'b1};
  assign next_kid1 = next_kid + KW'(1);
  assign index_inc = (&building_index) ? building_index : building_index + 1'b1;
  assign rise_ext = $signed({{(BW-H){1'b0}}, q_head.rise});
  assign top_ext = $signed({{(BW-H){1'b0}}, rd0});
  assign heap_full = (heap_fill == FW'(HEAP_DEPTH));
  assign out_free = !reach_valid || !reach_stall;
  assign q_pop = (state == ST_IDLE) && q_valid;

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = pos;
    mem_wdata = val;
    rd0_addr = '0;
    rd1_addr = '0;
    case (state)
      ST_IDLE: begin
        if (q_valid && q_head.kind == gcbh_pkg::KIND_RISE && !row_stopped && !heap_full) begin
          if (heap_fill == '0) begin
            mem_we = 1'b1;
            mem_waddr = '0;
            mem_wdata = q_head.rise;
          end else begin
            rd0_addr = fill_parent;
          end
        end
      end
      ST_PUSH_CMP: begin
        mem_we = 1'b1;
        if (rd0 < val) begin
          mem_wdata = rd0;
          rd0_addr = AW'((up - AW'(1)) >> 1);
        end
      end
      ST_PUSH_TOP: begin
        mem_we = 1'b1;
        mem_waddr = '0;
      end
      ST_CHECK: begin
        rd0_addr = '0;
        rd1_addr = AW'(fill_m1);
      end
      ST_POP_LOAD: begin
        rd0_addr = AW'(1);
        rd1_addr = AW'(2);
      end
      ST_DOWN_CMP: begin
        if (kid_val > val) begin
          mem_we = 1'b1;
          mem_wdata = kid_val;
          rd0_addr = next_kid[AW-1:0];
          rd1_addr = next_kid1[AW-1:0];
        end
      end
      ST_POP_END: begin
        mem_we = (heap_fill != '0);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rd0 <= heap_mem[rd0_addr];
    rd1 <= heap_mem[rd1_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      bricks <= '0;
      ladders <= '0;
      row_stopped <= 1'b0;
      building_index <= '0;
      heap_fill <= '0;
      reach_valid <= 1'b0;
    end else begin
      if (reach_valid && !reach_stall) begin
        reach_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            overflow <= 1'b0;
            state <= ST_FINISH;
            case (q_head.kind)
              gcbh_pkg::KIND_FIRST: begin
                bricks <= $signed({{(BW-gcbh_pkg::BUDGET_W){1'b0}}, cfg.brick_budget});
                ladders <= cfg.ladder_count;
                heap_fill <= '0;
                building_index <= '0;
                row_stopped <= 1'b0;
              end
              gcbh_pkg::KIND_RISE: begin
                if (!row_stopped) begin
                  bricks <= bricks - rise_ext;
                  val <= q_head.rise;
                  if (heap_full) begin
                    overflow <= 1'b1;
                    state <= ST_CHECK;
                  end else begin
                    heap_fill <= heap_fill + FW'(1);
                    pos <= AW'(heap_fill);
                    state <= (heap_fill == '0) ? ST_CHECK : ST_PUSH_CMP;
                  end
                end
              end
              default: begin
                if (!row_stopped) begin
                  building_index <= index_inc;
                end
              end
            endcase
          end
        end
        ST_PUSH_CMP: begin
          if (rd0 >= val) begin
            state <= ST_CHECK;
          end else begin
            pos <= up;
            if (up == '0) begin
              state <= ST_PUSH_TOP;
            end
          end
        end
        ST_PUSH_TOP: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (bricks[BW-1]) begin
            if (ladders == '0) begin
              row_stopped <= 1'b1;
              state <= ST_FINISH;
            end else begin
              ladders <= ladders - 1'b1;
              if (heap_fill == '0) begin
                building_index <= index_inc;
                state <= ST_FINISH;
              end else begin
                heap_fill <= fill_m1;
                state <= ST_POP_LOAD;
              end
            end
          end else begin
            building_index <= index_inc;
            state <= ST_FINISH;
          end
        end
        ST_POP_LOAD: begin
          bricks <= bricks + top_ext;
          val <= rd1;
          pos <= '0;
          state <= (heap_fill > FW'(1)) ? ST_DOWN_CMP : ST_POP_END;
        end
        ST_DOWN_CMP: begin
          if (kid_val > val) begin
            pos <= kid_pos[AW-1:0];
            if (next_kid >= fill_k) begin
              state <= ST_POP_END;
            end
          end else begin
            state <= ST_POP_END;
          end
        end
        ST_POP_END: begin
          building_index <= index_inc;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            reach_valid <= 1'b1;
            reach.reached_index <= building_index;
            reach.stopped <= row_stopped;
            reach.heap_overflow <= overflow;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/greedy_climb_budget_heap.sv
// Top level: configuration registers, front end, item queue and heap engine.
//
// Heights of a row arrive one item at a time; each item yields one result with the furthest
// index reached, a stopped flag and a heap overflow flag. A row start, a level or downward
// step, or any item after a stop goes from the idle state straight to the finish state; an
// upward step pushes its rise into a max-heap held in a single memory with one write and two
// read ports, sifting one level per cycle, and a pop when the bricks run short sifts down one
// level per cycle. A two-entry queue lets new items be taken while the heap works and while a
// result waits in the output register. The heap needs no clearing after reset.
module greedy_climb_budget_heap #(
  parameter int HEAP_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step_valid,
  output logic                                step_stall,
  input  gcbh_pkg::step_t                     step,
  output logic                                reach_valid,
  input  logic                                reach_stall,
  output gcbh_pkg::reach_t                    reach,
  input  logic                                cfg_we,
  input  logic [gcbh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gcbh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  gcbh_pkg::cfg_t   cfg;
  gcbh_pkg::entry_t q_entry;
  gcbh_pkg::entry_t q_head;
  logic             q_push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gcbh_pkg::REG_BRICK_BUDGET: begin
          cfg.brick_budget <= cfg_data[gcbh_pkg::BUDGET_W-1:0];
        end
        gcbh_pkg::REG_LADDER_COUNT: begin
          cfg.ladder_count <= cfg_data[gcbh_pkg::LADDER_W-1:0];
        end
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  gcbh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_stall (step_stall),
    .step       (step),
    .q_push     (q_push),
    .q_entry    (q_entry),
    .q_full     (q_full)
  );

  gcbh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head),
    .pop        (q_pop)
  );

  gcbh_back #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .reach_valid (reach_valid),
    .reach_stall (reach_stall),
    .reach       (reach)
  );

endmodule

// File: verif/gcbh_tb_pkg.sv
// Scoreboard class for the greedy climb budget heap testbench: reach predictor and result check.
`timescale 1ns / 1ps
package gcbh_tb_pkg;

  localparam int HEAP_SLOTS = 1024;
  localparam logic [gcbh_pkg::INDEX_W-1:0] INDEX_TOP = '1;

  class climb_scoreboard;
    logic [gcbh_pkg::HEIGHT_W-1:0] rises [HEAP_SLOTS];
    int unsigned fill;
    longint bricks;
    int ladders;
    logic [gcbh_pkg::HEIGHT_W-1:0] last_height;
    logic [gcbh_pkg::INDEX_W-1:0] reach_idx;
    bit halted;
    logic [gcbh_pkg::BUDGET_W-1:0] budget_reg;
    logic [gcbh_pkg::LADDER_W-1:0] ladder_reg;
    gcbh_pkg::reach_t reach_q[$];
    int errors;

    function new();
      fill = 0;
      bricks = 0;
      ladders = 0;
      last_height = '0;
      reach_idx = '0;
      halted = 0;
      budget_reg = '0;
      ladder_reg = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [gcbh_pkg::CFG_INDEX_W-1:0] idx,
                            logic [gcbh_pkg::CFG_DATA_W-1:0] data);
      if (idx == gcbh_pkg::REG_BRICK_BUDGET) begin
        budget_reg = data[gcbh_pkg::BUDGET_W-1:0];
      end else if (idx == gcbh_pkg::REG_LADDER_COUNT) begin
        ladder_reg = data[gcbh_pkg::LADDER_W-1:0];
      end
    endfunction

    function bit push_rise(logic [gcbh_pkg::HEIGHT_W-1:0] v);
      int unsigned pos;
      int unsigned up;
      if (fill >= HEAP_SLOTS) return 0;
      pos = fill;
      fill++;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (rises[up] >= v) break;
        rises[pos] = rises[up];
        pos = up;
      end
      rises[pos] = v;
      return 1;
    endfunction

    function logic [gcbh_pkg::HEIGHT_W-1:0] pop_rise();
      logic [gcbh_pkg::HEIGHT_W-1:0] top;
      logic [gcbh_pkg::HEIGHT_W-1:0] tail;
      int unsigned pos;
      int unsigned kid;
      if (fill == 0) return '0;
      top = rises[0];
      fill--;
      tail = rises[fill];
      pos = 0;
      while (1) begin
        kid = 2 * pos + 1;
        if (kid >= fill) break;
        if (kid + 1 < fill && rises[kid+1] > rises[kid]) kid++;
        if (rises[kid] <= tail) break;
        rises[pos] = rises[kid];
        pos = kid;
      end
      if (fill > 0) rises[pos] = tail;
      return top;
    endfunction

    // returns 1 when the item was not swallowed by a stopped row
    function bit note_step(gcbh_pkg::step_t s);
      gcbh_pkg::reach_t r;
      bit live;
      bit dropped;
      logic [gcbh_pkg::HEIGHT_W-1:0] rise;
      live = s.first || !halted;
      dropped = 0;
      if (s.first) begin
        bricks = {32'b0, budget_reg};
        ladders = {21'b0, ladder_reg};
        fill = 0;
        reach_idx = '0;
        halted = 0;
        last_height = s.height;
      end else if (!halted) begin
        if (s.height > last_height) begin
          rise = s.height - last_height;
          bricks = bricks - longint'({44'b0, rise});
          if (!push_rise(rise)) dropped = 1;
          if (bricks < 0) begin
            bricks = bricks + longint'({44'b0, pop_rise()});
            ladders--;
          end
        end
        last_height = s.height;
        if (ladders < 0) begin
          halted = 1;
        end else if (reach_idx != INDEX_TOP) begin
          reach_idx++;
        end
      end
      r.reached_index = reach_idx;
      r.stopped = halted;
      r.heap_overflow = dropped;
      reach_q = {reach_q, r};
      return live;
    endfunction

    function int pending();
      return reach_q.size();
    endfunction

    function bit is_halted();
      return halted;
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_reach(gcbh_pkg::reach_t got);
      gcbh_pkg::reach_t want;
      if (reach_q.size() == 0) begin
        report($sformatf("result with no item pending, index %0d", got.reached_index));
        return;
      end
      want = reach_q.pop_front();
      if (got.reached_index !== want.reached_index)
        report($sformatf("reached_index %0d, want %0d", got.reached_index, want.reached_index));
      if (got.stopped !== want.stopped)
        report($sformatf("stopped %0b, want %0b", got.stopped, want.stopped));
      if (got.heap_overflow !== want.heap_overflow)
        report($sformatf("heap_overflow %0b, want %0b", got.heap_overflow, want.heap_overflow));
    endtask
  endclass

endpackage

// File: verif/tb.sv
// Testbench top for the greedy climb budget heap: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps
module tb;

  localparam int HMAX = (1 << gcbh_pkg::HEIGHT_W) - 1;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             step_valid = 1'b0;
  logic                             step_stall;
  gcbh_pkg::step_t                  step = '0;
  logic                             reach_valid;
  logic                             reach_stall = 1'b0;
  gcbh_pkg::reach_t                 reach;
  logic                             cfg_we = 1'b0;
  logic [gcbh_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gcbh_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off = 0;
  int live_items = 0;
  gcbh_tb_pkg::climb_scoreboard sb = new();

  greedy_climb_budget_heap #(.HEAP_DEPTH(gcbh_tb_pkg::HEAP_SLOTS)) u_top (
    .clk(clk),
    .rst(rst),
    .step_valid(step_valid),
    .step_stall(step_stall),
    .step(step),
    .reach_valid(reach_valid),
    .reach_stall(reach_stall),
    .reach(reach),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    reach_stall = hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && reach_valid && !reach_stall) sb.check_reach(reach);
  end

  task automatic send_item(input gcbh_pkg::step_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      step_valid = 1'b0;
      @(negedge clk);
    end
    step_valid = 1'b1;
    step = s;
    do @(posedge clk); while (step_stall);
    if (sb.note_step(s)) live_items++;
    @(negedge clk);
  endtask

  task automatic put(int unsigned h, bit f);
    gcbh_pkg::step_t s;
    s.height = h[gcbh_pkg::HEIGHT_W-1:0];
    s.first = f;
    send_item(s);
  endtask

  task automatic write_reg(logic [gcbh_pkg::CFG_INDEX_W-1:0] idx,
                           logic [gcbh_pkg::CFG_DATA_W-1:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    step_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic configure(logic [gcbh_pkg::CFG_DATA_W-1:0] budget,
                           logic [gcbh_pkg::CFG_DATA_W-1:0] ladders);
    drain();
    write_reg(gcbh_pkg::REG_BRICK_BUDGET, budget);
    write_reg(gcbh_pkg::REG_LADDER_COUNT, ladders);
  endtask

  task automatic hold_stretch(int cycles);
    hold_off = 1;
    repeat (cycles) @(negedge clk);
    hold_off = 0;
  endtask

  // rows of random length; k sets the size of a typical step
  task automatic run_rows(int target, int k);
    int unsigned h;
    int unsigned d;
    int unsigned maxd;
    int goal;
    maxd = (1 << k) - 1;
    goal = live_items + target;
    h = 0;
    while (live_items < goal) begin
      if ($urandom_range(0, 9) != 0) begin
        h = $urandom_range(0, HMAX);
        put(h, 1'b1);
      end
      repeat ($urandom_range(1, 40)) begin
        if (sb.is_halted()) break;
        d = $urandom_range(1, maxd);
        case ($urandom_range(0, 9))
          0: h = $urandom_range(0, HMAX);
          1: h = h;
          2, 3, 4, 5: h = (h + d > HMAX) ? HMAX : h + d;
          6, 7, 8: h = (d > h) ? 0 : h - d;
          default: h = (h == HMAX) ? h : h + 1;
        endcase
        put(h, 1'b0);
      end
      // noise after a stop: these are ignored by the block
      if (sb.is_halted() && $urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) put($urandom_range(0, HMAX), 1'b0);
      end
    end
  endtask

  initial begin
    int k;
    logic [gcbh_pkg::CFG_DATA_W-1:0] budget;
    logic [gcbh_pkg::CFG_DATA_W-1:0] ladders;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no row started yet: zero budgets, first rise stops the row
    put(0, 1'b0);
    put(5, 1'b0);
    put(9, 1'b0);

    configure(10, 1);
    put(0, 1'b1);
    put(HMAX, 1'b0);
    put(0, 1'b0);
    put(0, 1'b0);
    put(3, 1'b0);
    put(7, 1'b0);
    put(11, 1'b0);
    put(2, 1'b0);

    configure(32'hFFFF_FFFF, 1024);
    put(HMAX, 1'b1);
    put(0, 1'b0);
    put(HMAX, 1'b0);
    put(HMAX, 1'b0);
    put(1, 1'b0);
    put(2, 1'b0);

    configure(0, 0);
    put(7, 1'b1);
    put(7, 1'b0);
    put(8, 1'b0);
    put(0, 1'b1);
    put(1, 1'b0);

    // one long row: fills the heap past its depth, then pops from a full heap
    configure(1030, 1024);
    put(0, 1'b1);
    for (int i = 1; i <= 1040; i++) put(i, 1'b0);
    repeat (5) put(1040, 1'b0);
    put(0, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      k = $urandom_range(1, gcbh_pkg::HEIGHT_W);
      case ($urandom_range(0, 5))
        0: budget = 0;
        1: budget = 32'hFFFF_FFFF;
        2: budget = $urandom();
        default: budget = $urandom_range(0, ((1 << k) - 1) * 6);
      endcase
      case ($urandom_range(0, 7))
        0: ladders = 0;
        1: ladders = 1024;
        2: ladders = $urandom_range(0, 1024);
        default: ladders = $urandom_range(1, 8);
      endcase
      configure(budget, ladders);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 77;
        end
        default: begin
          send_idle_pct = 21;
          stall_pct = 21;
        end
      endcase
      if (ph == 4) fork hold_stretch(400); join_none
      run_rows(25, k);
    end

    drain();
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: greedy_climb_budget_heap.f
src/gcbh_pkg.sv
src/gcbh_front.sv
src/gcbh_queue.sv
src/gcbh_back.sv
src/greedy_climb_budget_heap.sv
verif/gcbh_tb_pkg.sv
verif/tb.sv
